// ===== src/rmth_pkg.sv =====
// Package for the running median block: opcodes, status codes, states and helpers.
package rmth_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_QUERY  = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Heap engine commands.
	typedef enum logic [1:0] {
		HC_PUSH = 2'd0,
		HC_POP  = 2'd1,
		HC_TOP  = 2'd2
	} hcmd_t;

	typedef enum logic [3:0] {
		HS_IDLE,
		HS_TOPRD,
		HS_TOPWT,
		HS_PWRITE,
		HS_PRD,
		HS_PWT,
		HS_PCMP,
		HS_DLAST,
		HS_DLWT,
		HS_DWRITE,
		HS_DRDL,
		HS_DRDR,
		HS_DWT,
		HS_DCMP,
		HS_DSWAP
	} hstate_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_TOPL,
		CS_TOPU,
		CS_DECIDE,
		CS_MOVE_POP,
		CS_MOVE_PUSH,
		CS_PUSH,
		CS_CHECK,
		CS_DELETE,
		CS_MEDL,
		CS_MEDU,
		CS_OUT
	} cstate_t;

	// Request from the sequencer to one heap engine.
	typedef struct packed {
		logic        go;
		hcmd_t       cmd;
		logic [31:0] value;
	} hreq_t;

	// True when a must sit above b: greater for the max-heap, smaller for the min-heap.
	function automatic logic outranks(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic is_max);
		outranks = is_max ? (a > b) : (a < b);
	endfunction

endpackage

// ===== src/rmth_ram.sv =====
// Generic single-port RAM with registered read.
module rmth_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== src/rmth_heap.sv =====
// One heap: a RAM, its count and a sequencer that sifts entries up and down.
module rmth_heap #(
	parameter int unsigned DEPTH  = 514,
	parameter bit          IS_MAX = 1'b1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  rmth_pkg::hreq_t          req,
	output logic                     done,
	output logic [31:0]              top,
	output logic [$clog2(DEPTH+1)-1:0] cnt
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	rmth_pkg::hstate_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] idx_q, idx_d, par_q, par_d, best_q, best_d;
	logic [31:0]   cur_q, cur_d, oth_q, oth_d, bv_q, bv_d;
	logic [AW-1:0] addr;
	logic          we;
	logic [31:0]   wdata, rdata;
	logic [CW:0]   lidx, ridx;
	logic          done_d;

	rmth_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	assign lidx = (CW+1)'({idx_q, 1'b1});
	assign ridx = lidx + 1'b1;
	assign cnt  = cnt_q;
	assign top  = cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmth_pkg::HS_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= clear ? '0 : cnt_d;
			done    <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		par_q  <= par_d;
		best_q <= best_d;
		cur_q  <= cur_d;
		oth_q  <= oth_d;
		bv_q   <= bv_d;
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		par_d   = par_q;
		best_d  = best_q;
		cur_d   = cur_q;
		oth_d   = oth_q;
		bv_d    = bv_q;
		addr    = idx_q;
		we      = 1'b0;
		wdata   = cur_q;
		done_d  = 1'b0;
		case (state_q)
			rmth_pkg::HS_IDLE: begin
				if (req.go) begin
					case (req.cmd)
						rmth_pkg::HC_PUSH: begin
							idx_d   = cnt_q[AW-1:0];
							cur_d   = req.value;
							cnt_d   = cnt_q + 1'b1;
							state_d = rmth_pkg::HS_PWRITE;
						end
						rmth_pkg::HC_POP: begin
							cnt_d   = cnt_q - 1'b1;
							state_d = rmth_pkg::HS_DLAST;
						end
						default: begin
							state_d = rmth_pkg::HS_TOPRD;
						end
					endcase
				end
			end
			rmth_pkg::HS_TOPRD: begin
				addr    = '0;
				state_d = rmth_pkg::HS_TOPWT;
			end
			rmth_pkg::HS_TOPWT: begin
				cur_d   = rdata;
				done_d  = 1'b1;
				state_d = rmth_pkg::HS_IDLE;
			end
			// Sift up: the moving value stays in cur_q and is written at each level.
			rmth_pkg::HS_PWRITE: begin
				we    = 1'b1;
				addr  = idx_q;
				wdata = cur_q;
				if (idx_q == '0) begin
					state_d = rmth_pkg::HS_TOPRD;
				end else begin
					par_d   = AW'((idx_q - 1'b1) >> 1);
					state_d = rmth_pkg::HS_PRD;
				end
			end
			rmth_pkg::HS_PRD: begin
				addr    = par_q;
				state_d = rmth_pkg::HS_PWT;
			end
			rmth_pkg::HS_PWT: begin
				oth_d   = rdata;
				state_d = rmth_pkg::HS_PCMP;
			end
			rmth_pkg::HS_PCMP: begin
				if (rmth_pkg::outranks(cur_q, oth_q, IS_MAX)) begin
					we      = 1'b1;
					addr    = idx_q;
					wdata   = oth_q;
					idx_d   = par_q;
					state_d = rmth_pkg::HS_PWRITE;
				end else begin
					state_d = rmth_pkg::HS_TOPRD;
				end
			end
			// Sift down: the last entry goes to the root and sinks.
			rmth_pkg::HS_DLAST: begin
				addr    = cnt_q[AW-1:0];
				idx_d   = '0;
				state_d = rmth_pkg::HS_DLWT;
			end
			rmth_pkg::HS_DLWT: begin
				cur_d   = rdata;
				state_d = rmth_pkg::HS_DWRITE;
			end
			rmth_pkg::HS_DWRITE: begin
				we      = 1'b1;
				addr    = idx_q;
				wdata   = cur_q;
				best_d  = idx_q;
				bv_d    = cur_q;
				state_d = ({1'b0, lidx} < {2'b0, cnt_q}) ? rmth_pkg::HS_DRDL :
				          rmth_pkg::HS_TOPRD;
			end
			rmth_pkg::HS_DRDL: begin
				addr    = lidx[AW-1:0];
				state_d = rmth_pkg::HS_DRDR;
			end
			rmth_pkg::HS_DRDR: begin
				addr = ridx[AW-1:0];
				if (rmth_pkg::outranks(rdata, bv_q, IS_MAX)) begin
					best_d = lidx[AW-1:0];
					bv_d   = rdata;
				end
				state_d = rmth_pkg::HS_DWT;
			end
			rmth_pkg::HS_DWT: begin
				oth_d   = rdata;
				state_d = rmth_pkg::HS_DCMP;
			end
			rmth_pkg::HS_DCMP: begin
				if ((ridx < {1'b0, cnt_q}) && rmth_pkg::outranks(oth_q, bv_q, IS_MAX)) begin
					best_d = ridx[AW-1:0];
					bv_d   = oth_q;
				end
				state_d = rmth_pkg::HS_DSWAP;
			end
			rmth_pkg::HS_DSWAP: begin
				if (best_q == idx_q) begin
					state_d = rmth_pkg::HS_TOPRD;
				end else begin
					we      = 1'b1;
					addr    = idx_q;
					wdata   = bv_q;
					idx_d   = best_q;
					state_d = rmth_pkg::HS_DWRITE;
				end
			end
			default: state_d = rmth_pkg::HS_IDLE;
		endcase
	end

endmodule

// ===== src/rmth_ctrl.sv =====
// Operation sequencer: decides heap moves and forms the result beat.
module rmth_ctrl #(
	parameter int unsigned CAPACITY = 1024,
	parameter int unsigned CW       = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_go,
	input  logic [1:0]      op,
	input  logic [31:0]     val,
	output logic            busy,
	output logic            clear,
	output rmth_pkg::hreq_t lreq,
	output rmth_pkg::hreq_t ureq,
	input  logic            ldone,
	input  logic            udone,
	input  logic [31:0]     ltop,
	input  logic [31:0]     utop,
	input  logic [CW-1:0]   lcnt,
	input  logic [CW-1:0]   ucnt,
	output logic            res_go,
	output logic [31:0]     res_median,
	output logic            res_valid,
	output logic [1:0]      res_status
);

	rmth_pkg::cstate_t state_q, state_d;
	logic [31:0] v_q, v_d, lt_q, lt_d, ut_q, ut_d, med_q, med_d;
	logic [1:0]  st_q, st_d;
	logic        fl_q, fl_d;  // move goes lower to upper when set
	logic        pl_q, pl_d;  // final push targets lower when set
	logic        chk_q, chk_d;
	logic        mv_q, mv_d;  // push of the new value still owed after a move
	logic [CW:0] total;
	logic        wait_done;

	assign total = {1'b0, lcnt} + {1'b0, ucnt};
	assign busy  = (state_q != rmth_pkg::CS_IDLE);
	assign res_median = med_d;
	assign res_status = st_q;
	assign res_valid  = (total != '0);
	assign wait_done  = ldone | udone;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmth_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		v_q <= v_d; lt_q <= lt_d; ut_q <= ut_d; med_q <= med_d;
		st_q <= st_d; fl_q <= fl_d; pl_q <= pl_d; chk_q <= chk_d; mv_q <= mv_d;
	end

	always_comb begin
		state_d = state_q;
		v_d = v_q; lt_d = lt_q; ut_d = ut_q; med_d = med_q;
		st_d = st_q; fl_d = fl_q; pl_d = pl_q; chk_d = chk_q; mv_d = mv_q;
		lreq   = '{go: 1'b0, cmd: rmth_pkg::HC_TOP, value: v_q};
		ureq   = '{go: 1'b0, cmd: rmth_pkg::HC_TOP, value: v_q};
		clear  = 1'b0;
		res_go = 1'b0;
		case (state_q)
			rmth_pkg::CS_IDLE: begin
				if (in_go) begin
					v_d = val; st_d = rmth_pkg::ST_OK;
					case (rmth_pkg::op_t'(op))
						rmth_pkg::OP_INSERT: begin
							if (total >= (CW+1)'(CAPACITY)) begin
								st_d = rmth_pkg::ST_FULL; state_d = rmth_pkg::CS_MEDL;
							end else begin
								lreq.go = 1'b1; state_d = rmth_pkg::CS_TOPL;
							end
						end
						rmth_pkg::OP_CLEAR: begin
							clear = 1'b1; state_d = rmth_pkg::CS_MEDL;
						end
						default: begin
							if (total == '0) begin
								st_d = rmth_pkg::ST_EMPTY; state_d = rmth_pkg::CS_MEDL;
							end else if (op == rmth_pkg::OP_DELETE) begin
								if (lcnt >= ucnt) lreq = '{1'b1, rmth_pkg::HC_POP, v_q};
								else ureq = '{1'b1, rmth_pkg::HC_POP, v_q};
								state_d = rmth_pkg::CS_DELETE;
							end else begin
								state_d = rmth_pkg::CS_MEDL;
							end
						end
					endcase
				end
			end
			rmth_pkg::CS_TOPL: if (ldone) begin
				lt_d = ltop; ureq.go = 1'b1; state_d = rmth_pkg::CS_TOPU;
			end
			rmth_pkg::CS_TOPU: if (udone) begin
				ut_d = utop; state_d = rmth_pkg::CS_DECIDE;
			end
			rmth_pkg::CS_DECIDE: begin
				chk_d = 1'b0;
				mv_d  = 1'b0;
				state_d = rmth_pkg::CS_PUSH;
				if (lcnt == '0 && ucnt == '0) begin
					pl_d = 1'b1;
				end else if (lcnt == '0) begin
					if ($signed(v_q) <= $signed(ut_q)) pl_d = 1'b1;
					else begin
						pl_d = 1'b0; fl_d = 1'b0; mv_d = 1'b1;
						state_d = rmth_pkg::CS_MOVE_POP;
					end
				end else if (ucnt == '0) begin
					if ($signed(v_q) >= $signed(lt_q)) pl_d = 1'b0;
					else begin
						pl_d = 1'b1; fl_d = 1'b1; mv_d = 1'b1;
						state_d = rmth_pkg::CS_MOVE_POP;
					end
				end else if ($signed(v_q) <= $signed(lt_q)) begin
					pl_d = 1'b1; chk_d = 1'b1;
				end else if ($signed(v_q) >= $signed(ut_q)) begin
					pl_d = 1'b0; chk_d = 1'b1;
				end else begin
					pl_d = (lcnt <= ucnt);
				end
			end
			// A move pops the top of one heap and pushes it onto the other.
			rmth_pkg::CS_MOVE_POP: begin
				if (fl_q) lreq = '{1'b1, rmth_pkg::HC_POP, lt_q};
				else ureq = '{1'b1, rmth_pkg::HC_POP, ut_q};
				state_d = rmth_pkg::CS_MOVE_PUSH;
			end
			rmth_pkg::CS_MOVE_PUSH: if (wait_done) begin
				if (fl_q) ureq = '{1'b1, rmth_pkg::HC_PUSH, lt_q};
				else lreq = '{1'b1, rmth_pkg::HC_PUSH, ut_q};
				state_d = rmth_pkg::CS_CHECK;
			end
			rmth_pkg::CS_PUSH: begin
				if (pl_q) lreq = '{1'b1, rmth_pkg::HC_PUSH, v_q};
				else ureq = '{1'b1, rmth_pkg::HC_PUSH, v_q};
				state_d = rmth_pkg::CS_CHECK;
			end
			rmth_pkg::CS_CHECK: if (wait_done) begin
				lt_d = ltop; ut_d = utop;
				if (mv_q) begin
					// A move made room first; the new value goes in now.
					mv_d = 1'b0; state_d = rmth_pkg::CS_PUSH;
				end else if (chk_q && pl_q && ({1'b0, lcnt} > {1'b0, ucnt} + 1'b1)) begin
					chk_d = 1'b0; fl_d = 1'b1; state_d = rmth_pkg::CS_MOVE_POP;
				end else if (chk_q && !pl_q && ({1'b0, ucnt} > {1'b0, lcnt} + 1'b1)) begin
					chk_d = 1'b0; fl_d = 1'b0; state_d = rmth_pkg::CS_MOVE_POP;
				end else begin
					state_d = rmth_pkg::CS_MEDL;
				end
			end
			rmth_pkg::CS_DELETE: if (wait_done) state_d = rmth_pkg::CS_MEDL;
			rmth_pkg::CS_MEDL: begin
				lreq.go = 1'b1; state_d = rmth_pkg::CS_MEDU;
			end
			rmth_pkg::CS_MEDU: if (ldone) begin
				lt_d = ltop; ureq.go = 1'b1; state_d = rmth_pkg::CS_OUT;
			end
			rmth_pkg::CS_OUT: if (udone) begin
				if (total == '0) med_d = '0;
				else med_d = (lcnt >= ucnt) ? lt_q : utop;
				res_go  = 1'b1;
				state_d = rmth_pkg::CS_IDLE;
			end
			default: state_d = rmth_pkg::CS_IDLE;
		endcase
	end

endmodule

// ===== src/running_median_two_heaps_top.sv =====
// Top level of the running median block built from two heaps.
//
//  Channel | Handshake       | Fields
//  in      | in_valid/stall  | operation, value
//  out     | out_valid/stall | median, median_valid, status, count
//
// An insert does a push, and may add a rebalancing pop and a second push, each
// sifting through the heap; each heap engine works through reads, compares and
// writes on its single RAM port.
// Query, clear and flagged items end with a read of the two tops; a delete adds
// one sift down first.
// Reset clears both counts; the heap RAMs are not cleared.
// The result waits in an output register; in_stall stays high while an item
// is in work or its result has not yet been taken.
module running_median_two_heaps_top #(
	parameter int unsigned CAPACITY = rmth_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] median,
	output logic               median_valid,
	output logic [1:0]         status,
	output logic [10:0]        count
);

	localparam int unsigned HDEPTH = CAPACITY / 2 + 2;
	localparam int unsigned CW     = $clog2(HDEPTH + 1);

	logic            busy, clear, ldone, udone, res_go, res_valid, in_go;
	rmth_pkg::hreq_t lreq, ureq;
	logic [31:0]     ltop, utop, res_median;
	logic [CW-1:0]   lcnt, ucnt;
	logic [1:0]      res_status;
	logic [CW:0]     total;

	// Take a new beat only when nothing is in work and the output is empty.
	assign in_stall = busy | out_valid;
	assign in_go    = in_valid & ~in_stall;
	assign total    = {1'b0, lcnt} + {1'b0, ucnt};

	rmth_heap #(.DEPTH(HDEPTH), .IS_MAX(1'b1)) u_lower (
		.clk(clk), .arst_n(arst_n), .clear(clear), .req(lreq),
		.done(ldone), .top(ltop), .cnt(lcnt)
	);

	rmth_heap #(.DEPTH(HDEPTH), .IS_MAX(1'b0)) u_upper (
		.clk(clk), .arst_n(arst_n), .clear(clear), .req(ureq),
		.done(udone), .top(utop), .cnt(ucnt)
	);

	rmth_ctrl #(.CAPACITY(CAPACITY), .CW(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .op(operation), .val(value),
		.busy(busy), .clear(clear), .lreq(lreq), .ureq(ureq),
		.ldone(ldone), .udone(udone), .ltop(ltop), .utop(utop),
		.lcnt(lcnt), .ucnt(ucnt), .res_go(res_go), .res_median(res_median),
		.res_valid(res_valid), .res_status(res_status)
	);

	// Output register: loaded as the sequencer finishes, held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_go) begin
			median       <= res_median;
			median_valid <= res_valid;
			status       <= res_status;
			count        <= 11'(total);
		end
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("beat accepted while busy");
	a_counts_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ({1'b0, lcnt} <= {1'b0, ucnt} + 1'b1 && {1'b0, ucnt} <= {1'b0, lcnt} + 1'b1))
		else $error("heap sizes out of balance");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		res_go |=> !busy) else $error("sequencer did not return to idle");
`endif

endmodule

// ===== tb/median_checker.sv =====
// Checker for the running median block: predicts each result and compares it.
`timescale 1ns / 100ps
module median_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         operation,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] median,
	input  logic               median_valid,
	input  logic [1:0]         status,
	input  logic [10:0]        count,
	output int                 fail_count,
	output int                 pending
);

	localparam int unsigned CAP = rmth_pkg::CAPACITY_DEF;

	typedef struct {
		logic signed [31:0]  med;
		logic                valid;
		rmth_pkg::status_t   st;
		logic [10:0]         cnt;
	} median_result_t;

	logic signed [31:0] low_half[$];
	logic signed [31:0] high_half[$];
	median_result_t     awaited[$];

	initial fail_count = 0;
	assign pending = awaited.size();

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Largest of the lower half.
	function automatic int low_top_idx();
		int k;
		k = 0;
		foreach (low_half[i]) if (low_half[i] > low_half[k]) k = i;
		return k;
	endfunction

	function automatic int high_top_idx();
		int k;
		k = 0;
		foreach (high_half[i]) if (high_half[i] < high_half[k]) k = i;
		return k;
	endfunction

	// The median depends only on the multiset in each half, so plain queues suffice.
	task automatic move_low_to_high();
		int k;
		k = low_top_idx();
		high_half.push_back(low_half[k]);
		low_half.delete(k);
	endtask

	task automatic move_high_to_low();
		int k;
		k = high_top_idx();
		low_half.push_back(high_half[k]);
		high_half.delete(k);
	endtask

	task automatic insert_value(input logic signed [31:0] v);
		int nl, nh;
		nl = low_half.size();
		nh = high_half.size();
		if (nl == 0 && nh == 0) begin
			low_half.push_back(v);
		end else if (nl == 0) begin
			if (v <= high_half[high_top_idx()]) begin
				low_half.push_back(v);
			end else begin
				move_high_to_low();
				high_half.push_back(v);
			end
		end else if (nh == 0) begin
			if (v >= low_half[low_top_idx()]) begin
				high_half.push_back(v);
			end else begin
				move_low_to_high();
				low_half.push_back(v);
			end
		end else if (v <= low_half[low_top_idx()]) begin
			low_half.push_back(v);
			if (low_half.size() > high_half.size() + 1) move_low_to_high();
		end else if (v >= high_half[high_top_idx()]) begin
			high_half.push_back(v);
			if (high_half.size() > low_half.size() + 1) move_high_to_low();
		end else if (nl <= nh) begin
			low_half.push_back(v);
		end else begin
			high_half.push_back(v);
		end
	endtask

	task automatic predict_median(input rmth_pkg::op_t op, input logic signed [31:0] v);
		median_result_t r;
		int total;
		r.st = rmth_pkg::ST_OK;
		total = low_half.size() + high_half.size();
		case (op)
			rmth_pkg::OP_INSERT: begin
				if (total >= CAP) r.st = rmth_pkg::ST_FULL;
				else insert_value(v);
			end
			rmth_pkg::OP_QUERY, rmth_pkg::OP_DELETE: begin
				if (total == 0) r.st = rmth_pkg::ST_EMPTY;
				else if (op == rmth_pkg::OP_DELETE) begin
					if (low_half.size() >= high_half.size()) low_half.delete(low_top_idx());
					else high_half.delete(high_top_idx());
				end
			end
			default: begin
				low_half.delete();
				high_half.delete();
			end
		endcase
		total = low_half.size() + high_half.size();
		r.med = 0;
		if (total != 0)
			r.med = (low_half.size() >= high_half.size()) ? low_half[low_top_idx()]
				: high_half[high_top_idx()];
		r.valid = (total != 0);
		r.cnt = total[10:0];
		awaited.push_back(r);
	endtask

	always @(posedge clk) begin
		median_result_t e;
		if (arst_n && in_valid && !in_stall)
			predict_median(rmth_pkg::op_t'(operation), value);
		if (arst_n && out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				report("result with no item outstanding");
			end else begin
				e = awaited.pop_front();
				if (median !== e.med)
					report($sformatf("median %0d, expected %0d", median, e.med));
				if (median_valid !== e.valid)
					report($sformatf("median_valid %0b, expected %0b", median_valid, e.valid));
				if (status !== e.st)
					report($sformatf("status %0d, expected %0d", status, e.st));
				if (count !== e.cnt)
					report($sformatf("count %0d, expected %0d", count, e.cnt));
			end
		end
	end
endmodule

// ===== tb/testbench.sv =====
// Top of the running median testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] median;
	logic               median_valid;
	logic [1:0]         status;
	logic [10:0]        count;
	int                 fail_count;
	int                 pending;

	// Held by the sender while it wants the receiver to take one long hold-off.
	logic               hold_request;

	running_median_two_heaps_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.median(median), .median_valid(median_valid),
		.status(status), .count(count)
	);

	median_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.median(median), .median_valid(median_valid),
		.status(status), .count(count),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Extreme values, and ones near zero, are weighted in so that the sign bit
	// and ties get plenty of exercise.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return $signed(32'($urandom_range(0, 6))) - 3;
			default: return $signed($urandom());
		endcase
	endfunction

	// Sends one beat: valid rises at a clock edge and stays until the block takes
	// it. Valid is lowered only when the sender really goes idle, so back-to-back
	// beats never see valid dropped and raised in the same step.
	task automatic send_beat(input rmth_pkg::op_t op, input logic signed [31:0] v);
		in_valid  <= 1'b1;
		operation <= op;
		value     <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Waits with nothing on offer until every expected result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Random operation mix: mostly inserts, which keep the store deep, with
	// deletes, queries and the occasional clear.
	function automatic rmth_pkg::op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return rmth_pkg::OP_INSERT;
		if (r < 75) return rmth_pkg::OP_DELETE;
		if (r < 98) return rmth_pkg::OP_QUERY;
		return rmth_pkg::OP_CLEAR;
	endfunction

	// Receiver: stalls on a rhythm of its own, sometimes not at all, and once
	// holds off for a long stretch on the sender's request.
	initial begin
		int mode;
		int n;
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				n = $urandom_range(1, 30);
				repeat (n) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= 1'b1;
						default: out_stall <= ($urandom_range(0, 2) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		in_valid     = 1'b0;
		operation    = rmth_pkg::OP_QUERY;
		value        = '0;
		hold_request = 1'b0;
		arst_n       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty cases first, then extremes, ties and a clear.
		send_beat(rmth_pkg::OP_QUERY, 32'sd0);
		send_beat(rmth_pkg::OP_DELETE, 32'sd0);
		send_beat(rmth_pkg::OP_INSERT, 32'sh7fff_ffff);
		send_beat(rmth_pkg::OP_INSERT, 32'sh8000_0000);
		send_beat(rmth_pkg::OP_QUERY, 32'sh7fff_ffff);
		send_beat(rmth_pkg::OP_INSERT, 32'sd0);
		send_beat(rmth_pkg::OP_INSERT, 32'sd0);
		send_beat(rmth_pkg::OP_INSERT, -32'sd1);
		send_beat(rmth_pkg::OP_INSERT, 32'sd0);
		send_beat(rmth_pkg::OP_INSERT, 32'sh5555_5555);
		send_beat(rmth_pkg::OP_INSERT, 32'shaaaa_aaaa);
		send_beat(rmth_pkg::OP_DELETE, 32'sd0);
		send_beat(rmth_pkg::OP_DELETE, 32'sd0);
		send_beat(rmth_pkg::OP_CLEAR, 32'sd0);
		send_beat(rmth_pkg::OP_QUERY, 32'sd0);
		send_beat(rmth_pkg::OP_INSERT, 32'sd5);
		send_beat(rmth_pkg::OP_DELETE, 32'sd0);
		send_beat(rmth_pkg::OP_DELETE, 32'sd0);
		send_beat(rmth_pkg::OP_INSERT, 32'sd7);
		send_beat(rmth_pkg::OP_CLEAR, 32'sd0);
		drain();

		// Fill to capacity and push past it to reach the full case. This is
		// long, so the sender goes without gaps here.
		for (int i = 0; i < 1026; i++) begin
			send_beat(rmth_pkg::OP_INSERT, pick_value());
		end
		send_beat(rmth_pkg::OP_QUERY, 32'sd0);
		for (int i = 0; i < 8; i++) begin
			send_beat(rmth_pkg::OP_DELETE, 32'sd0);
		end
		send_beat(rmth_pkg::OP_CLEAR, 32'sd0);

		// The receiver holds off while the sender keeps offering, so the output
		// register stays full and the block stalls its input.
		hold_request <= 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_beat(pick_op(), pick_value());
		end
		hold_request <= 1'b0;
		drain();

		// Random part in bursts with gaps.
		for (int sent = 0; sent < 30; ) begin
			int burst;
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst; j++) begin
				send_beat(pick_op(), pick_value());
				sent++;
			end
			if ($urandom_range(0, 9) == 0) drain();
			else if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 60));
		end

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Slowest run: about 1100 items with stalls, plus the long hold-off and the
	// gaps, stays far below this limit.
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end
endmodule
